[rtl/gapf_pkg.sv]
// gapf_pkg: shared constants, codes and types of the grid path finder
// used by the channel interfaces, the heuristic unit and the top level
// no dependencies
package gapf_pkg;

   // grid geometry
   localparam int GRID_DIM = 32;
   localparam int COORD_W  = $clog2(GRID_DIM);
   localparam int IDX_W    = 2 * COORD_W;
   localparam int TILES    = GRID_DIM * GRID_DIM;
   localparam int CNT_W    = IDX_W + 1;
   localparam int DIM_W    = COORD_W + 1;

   // field widths
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int STEP_W = 10;
   localparam int LEN_W  = 11;

   // per-tile search record widths
   localparam int MARK_W = 2;
   localparam int G_W    = 16;
   localparam int DIR_W  = 3;
   localparam int ORD_W  = IDX_W;
   localparam int H_W    = 9;
   localparam int V_W    = 2 * H_W;

   // costs in tenths of a tile
   localparam int COST_STRAIGHT = 10;
   localparam int COST_DIAG     = 14;
   localparam int HEUR_SCALE    = 100;

   // list marks
   localparam logic [MARK_W-1:0] MARK_NONE   = 2'd0;
   localparam logic [MARK_W-1:0] MARK_OPEN   = 2'd1;
   localparam logic [MARK_W-1:0] MARK_CLOSED = 2'd2;

   // commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOPATH = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd3;

   // register indexes
   localparam logic [0:0] REG_MAP_WIDTH  = 1'b0;
   localparam logic [0:0] REG_MAP_HEIGHT = 1'b1;

   // one word of the tile memory
   typedef struct packed {
      logic [MARK_W-1:0] mark;
      logic [G_W-1:0]    g;
      logic [DIR_W-1:0]  dir;
      logic [ORD_W-1:0]  ord;
      logic [H_W-1:0]    h;
   } tile_type;

   // heuristic unit request and answer
   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] ey;
   } heur_req_type;

   typedef struct packed {
      logic           done;
      logic [H_W-1:0] h;
   } heur_rsp_type;

endpackage

[rtl/gapf_req_if.sv]
// gapf_req_if: command channel of the grid path finder
// depends on gapf_pkg
interface gapf_req_if import gapf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;
   logic               occupied_value;
   logic [STEP_W-1:0]  step_index;

   modport source (output valid, command, start_x, start_y, end_x, end_y,
                   occupied_value, step_index, input ready);
   modport sink (input valid, command, start_x, start_y, end_x, end_y,
                 occupied_value, step_index, output ready);
endinterface

[rtl/gapf_rsp_if.sv]
// gapf_rsp_if: result channel of the grid path finder
// depends on gapf_pkg
interface gapf_rsp_if import gapf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [LEN_W-1:0]   path_length;
   logic [COORD_W-1:0] step_x;
   logic [COORD_W-1:0] step_y;

   modport source (output valid, status, path_length, step_x, step_y, input ready);
   modport sink (input valid, status, path_length, step_x, step_y, output ready);
endinterface

[rtl/gapf_heur.sv]
// gapf_heur: heuristic unit, round(sqrt(100*(dx*dx+dy*dy))) by a digit-serial root
// one result bit per cycle; differences, square sum and scaling are registered first
// depends on gapf_pkg
module gapf_heur import gapf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  heur_req_type heur_req,
   output heur_rsp_type heur_rsp
);

   localparam int SQ_W  = 2 * COORD_W + 1;
   localparam int REM_W = H_W + 1;
   localparam int IT_W  = $clog2(H_W);

   localparam logic [1:0] HS_IDLE = 2'd0;
   localparam logic [1:0] HS_SQ   = 2'd1;
   localparam logic [1:0] HS_MUL  = 2'd2;
   localparam logic [1:0] HS_ROOT = 2'd3;

   logic [1:0]         hs_ff, hs_in;
   logic [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [V_W-1:0]     val_ff, val_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [H_W-1:0]     root_ff, root_in;
   logic [IT_W-1:0]    it_ff, it_in;
   logic               done_ff, done_in;
   logic [H_W-1:0]     h_ff, h_in;

   logic [SQ_W-1:0]    axw, ayw;
   logic [REM_W+1:0]   rem2, trial, rem_sub;
   logic               ge;
   logic [REM_W-1:0]   rem_new;
   logic [H_W-1:0]     root_new;

   // one root digit
   always_comb begin
      axw      = SQ_W'(ax_ff);
      ayw      = SQ_W'(ay_ff);
      rem2     = {rem_ff, val_ff[V_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      ge       = rem2 >= trial;
      rem_sub  = ge ? (rem2 - trial) : rem2;
      rem_new  = rem_sub[REM_W-1:0];
      root_new = {root_ff[H_W-2:0], ge};
   end

   // sequencer
   always_comb begin
      hs_in   = hs_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      sq_in   = sq_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      it_in   = it_ff;
      done_in = 1'b0;
      h_in    = h_ff;
      unique case (hs_ff)
         HS_IDLE: begin
            if (heur_req.start) begin
               ax_in = (heur_req.x >= heur_req.ex) ? heur_req.x - heur_req.ex
                                                   : heur_req.ex - heur_req.x;
               ay_in = (heur_req.y >= heur_req.ey) ? heur_req.y - heur_req.ey
                                                   : heur_req.ey - heur_req.y;
               hs_in = HS_SQ;
            end
         end
         HS_SQ: begin
            sq_in = axw * axw + ayw * ayw;
            hs_in = HS_MUL;
         end
         HS_MUL: begin
            val_in  = V_W'(sq_ff) * V_W'(HEUR_SCALE);
            rem_in  = '0;
            root_in = '0;
            it_in   = '0;
            hs_in   = HS_ROOT;
         end
         HS_ROOT: begin
            val_in  = {val_ff[V_W-3:0], 2'b00};
            rem_in  = rem_new;
            root_in = root_new;
            it_in   = it_ff + IT_W'(1);
            if (it_ff == IT_W'(H_W - 1)) begin
               // round half up: remainder above the root
               h_in    = root_new + H_W'(rem_new > {1'b0, root_new});
               done_in = 1'b1;
               hs_in   = HS_IDLE;
            end
         end
         default: hs_in = HS_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff   <= HS_IDLE;
         done_ff <= 1'b0;
      end else begin
         hs_ff   <= hs_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      sq_ff   <= sq_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      it_ff   <= it_in;
      h_ff    <= h_in;
   end

   assign heur_rsp.done = done_ff;
   assign heur_rsp.h    = h_ff;

endmodule

[rtl/grid_astar_path_finder.sv]
// grid_astar_path_finder: eight-connected A* search over a tile occupancy grid
// holds the occupancy, tile and path memories and the search sequencer
// depends on gapf_pkg, gapf_req_if, gapf_rsp_if, gapf_heur
//
// Usage: req_ch carries one command word (write tile, find path, read step),
// rsp_ch returns exactly one result word per command, in order. csr_we with
// csr_index/csr_wdata sets map_width (0) and map_height (1); the user must
// do so only while idle, which the block itself does not enforce.
// After reset the occupancy memory is swept clear, one tile per cycle, while
// req_ch.ready stays low. Both map registers reset to 32. A write passes
// through S_WR, a read through S_RD and S_RDW, to the result register.
// A find sweeps the tile memory clear, then each expansion scans the whole
// tile memory through its single read port and visits the eight neighbours,
// waiting on the heuristic unit for each newly opened tile. Building the
// path traces the parents twice, then the grid update moves the unit.
// Items are taken one at a time; a new command is accepted while the
// previous result still waits in the output register. If rsp_ch stalls,
// the finished result is held and the block waits before handing over
// the next one.
module grid_astar_path_finder import gapf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   gapf_req_if.sink         req_ch,
   gapf_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   localparam int SC_W = COORD_W + 2;
   localparam int F_W  = G_W + 1;
   localparam logic [DIM_W-1:0] GRID_V = DIM_W'(GRID_DIM);

   localparam logic [SC_W-1:0] STEP_DX [8] = '{SC_W'(-1), SC_W'(-1), SC_W'(0), SC_W'(1),
                                               SC_W'(1), SC_W'(1), SC_W'(0), SC_W'(-1)};
   localparam logic [SC_W-1:0] STEP_DY [8] = '{SC_W'(0), SC_W'(1), SC_W'(1), SC_W'(1),
                                               SC_W'(0), SC_W'(-1), SC_W'(-1), SC_W'(-1)};

   // sequencer states
   localparam logic [4:0] S_RCLR  = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_WR    = 5'd2;
   localparam logic [4:0] S_RD    = 5'd3;
   localparam logic [4:0] S_RDW   = 5'd4;
   localparam logic [4:0] S_FCLR  = 5'd5;
   localparam logic [4:0] S_FHS   = 5'd6;
   localparam logic [4:0] S_FHW   = 5'd7;
   localparam logic [4:0] S_CHK   = 5'd8;
   localparam logic [4:0] S_SCAN  = 5'd9;
   localparam logic [4:0] S_CLOSE = 5'd10;
   localparam logic [4:0] S_NBR   = 5'd11;
   localparam logic [4:0] S_NEV   = 5'd12;
   localparam logic [4:0] S_NH    = 5'd13;
   localparam logic [4:0] S_POCC  = 5'd14;
   localparam logic [4:0] S_PEO   = 5'd15;
   localparam logic [4:0] S_P1    = 5'd16;
   localparam logic [4:0] S_P1E   = 5'd17;
   localparam logic [4:0] S_P2    = 5'd18;
   localparam logic [4:0] S_P2E   = 5'd19;
   localparam logic [4:0] S_MV0   = 5'd20;
   localparam logic [4:0] S_MV1   = 5'd21;
   localparam logic [4:0] S_DONE  = 5'd22;

   // control registers
   logic [4:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIM_W-1:0]   map_w_ff, map_w_in, map_h_ff, map_h_in;
   logic [LEN_W-1:0]   stored_len_ff, stored_len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff, found_in;
   logic               end_open_ff, end_open_in;
   logic [DIR_W-1:0]   d_ff, d_in;

   // payload registers
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic               occv_ff, occv_in;
   logic [STEP_W-1:0]  si_ff, si_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   tile_type           best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [F_W-1:0]     best_f_ff, best_f_in;
   logic [IDX_W-1:0]   nidx_ff, nidx_in;
   logic [G_W-1:0]     gnew_ff, gnew_in;
   logic [ORD_W-1:0]   order_ff, order_in;
   logic               end_occ_ff, end_occ_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic [CNT_W-1:0]   full_ff, full_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   fin_ff, fin_in;

   // memories and their ports
   logic               occ_mem [TILES];
   tile_type           tile_mem [TILES];
   logic [IDX_W-1:0]   path_mem [TILES];
   logic               occ_rd_ff;
   tile_type           tile_rd_ff;
   logic [IDX_W-1:0]   path_rd_ff;
   logic               occ_we, occ_wdata;
   logic [IDX_W-1:0]   occ_waddr, occ_raddr;
   logic               tile_we;
   tile_type           tile_wdata;
   logic [IDX_W-1:0]   tile_waddr, tile_raddr;
   logic               path_we;
   logic [IDX_W-1:0]   path_waddr;

   // heuristic unit
   heur_req_type       heur_req;
   heur_rsp_type       heur_rsp;

   gapf_heur u_heur (
      .clock    (clock),
      .reset    (reset),
      .heur_req (heur_req),
      .heur_rsp (heur_rsp)
   );

   // derived values
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [IDX_W-1:0]   s_idx, e_idx;
   logic               start_ok, end_ok;
   logic [SC_W-1:0]    nx, ny, px, py;
   logic               n_in_map, p_ok;
   logic [IDX_W-1:0]   n_idx, p_idx;
   logic [F_W-1:0]     f_c;
   logic               take;
   logic [G_W-1:0]     gnew_c;
   logic               blocked;
   logic [CNT_W-1:0]   k_c;

   always_comb begin
      w_eff    = (map_w_ff > GRID_V) ? GRID_V : map_w_ff;
      h_eff    = (map_h_ff > GRID_V) ? GRID_V : map_h_ff;
      s_idx    = {sy_ff, sx_ff};
      e_idx    = {ey_ff, ex_ff};
      start_ok = ({1'b0, req_ch.start_x} < w_eff) && ({1'b0, req_ch.start_y} < h_eff);
      end_ok   = ({1'b0, req_ch.end_x} < w_eff) && ({1'b0, req_ch.end_y} < h_eff);
      // neighbour of the expanded tile in direction d
      nx       = SC_W'(best_idx_ff[COORD_W-1:0]) + STEP_DX[d_ff];
      ny       = SC_W'(best_idx_ff[IDX_W-1:COORD_W]) + STEP_DY[d_ff];
      n_in_map = !nx[SC_W-1] && !ny[SC_W-1] && (nx[DIM_W-1:0] < w_eff)
                 && (ny[DIM_W-1:0] < h_eff);
      n_idx    = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
      // parent of the traced tile
      px       = SC_W'(pidx_ff[COORD_W-1:0]) - STEP_DX[tile_rd_ff.dir];
      py       = SC_W'(pidx_ff[IDX_W-1:COORD_W]) - STEP_DY[tile_rd_ff.dir];
      p_ok     = !px[SC_W-1] && !py[SC_W-1] && (px[DIM_W-1:0] < GRID_V)
                 && (py[DIM_W-1:0] < GRID_V);
      p_idx    = p_ok ? {py[COORD_W-1:0], px[COORD_W-1:0]} : pidx_ff;
      // minimum scan: smaller f, ties to the earlier insert
      f_c      = F_W'(tile_rd_ff.g) + F_W'(tile_rd_ff.h);
      take     = (tile_rd_ff.mark == MARK_OPEN)
                 && (!found_ff || (f_c < best_f_ff)
                     || ((f_c == best_f_ff) && (tile_rd_ff.ord < best_ff.ord)));
      gnew_c   = best_ff.g + (d_ff[0] ? G_W'(COST_DIAG) : G_W'(COST_STRAIGHT));
      blocked  = occ_rd_ff && (nidx_ff != e_idx);
      k_c      = cnt_ff - CNT_W'(1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      map_w_in      = map_w_ff;
      map_h_in      = map_h_ff;
      stored_len_in = stored_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      found_in      = found_ff;
      end_open_in   = end_open_ff;
      d_in          = d_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      occv_in       = occv_ff;
      si_in         = si_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_f_in     = best_f_ff;
      nidx_in       = nidx_ff;
      gnew_in       = gnew_ff;
      order_in      = order_ff;
      end_occ_in    = end_occ_ff;
      pidx_in       = pidx_ff;
      full_in       = full_ff;
      len_in        = len_ff;
      fin_in        = fin_ff;

      occ_we        = 1'b0;
      occ_waddr     = s_idx;
      occ_wdata     = 1'b0;
      occ_raddr     = n_idx;
      tile_we       = 1'b0;
      tile_waddr    = nidx_ff;
      tile_wdata    = '0;
      tile_raddr    = n_idx;
      path_we       = 1'b0;
      path_waddr    = k_c[IDX_W-1:0];

      heur_req.start = 1'b0;
      heur_req.x     = nidx_ff[COORD_W-1:0];
      heur_req.y     = nidx_ff[IDX_W-1:COORD_W];
      heur_req.ex    = ex_ff;
      heur_req.ey    = ey_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            REG_MAP_WIDTH:  map_w_in = csr_wdata;
            REG_MAP_HEIGHT: map_h_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_RCLR: begin
            occ_we    = 1'b1;
            occ_waddr = cnt_ff[IDX_W-1:0];
            if (cnt_ff[IDX_W-1:0] == IDX_W'(TILES - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               sx_in         = req_ch.start_x;
               sy_in         = req_ch.start_y;
               ex_in         = req_ch.end_x;
               ey_in         = req_ch.end_y;
               occv_in       = req_ch.occupied_value;
               si_in         = req_ch.step_index;
               res_status_in = STAT_RANGE;
               res_x_in      = '0;
               res_y_in      = '0;
               state_in      = S_DONE;
               unique case (req_ch.command)
                  CMD_WRITE: if (start_ok) state_in = S_WR;
                  CMD_FIND: begin
                     if (start_ok && end_ok) begin
                        cnt_in   = '0;
                        state_in = S_FCLR;
                     end
                  end
                  CMD_READ: begin
                     if (LEN_W'(req_ch.step_index) < stored_len_ff) state_in = S_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_WR: begin
            occ_we        = 1'b1;
            occ_wdata     = occv_ff;
            res_status_in = STAT_DONE;
            state_in      = S_DONE;
         end
         S_RD: state_in = S_RDW;
         S_RDW: begin
            res_x_in      = path_rd_ff[COORD_W-1:0];
            res_y_in      = path_rd_ff[IDX_W-1:COORD_W];
            res_status_in = STAT_DONE;
            state_in      = S_DONE;
         end
         // clear the list marks
         S_FCLR: begin
            tile_we     = 1'b1;
            tile_waddr  = cnt_ff[IDX_W-1:0];
            end_open_in = 1'b0;
            if (cnt_ff[IDX_W-1:0] == IDX_W'(TILES - 1)) begin
               state_in = S_FHS;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FHS: begin
            heur_req.start = 1'b1;
            heur_req.x     = sx_ff;
            heur_req.y     = sy_ff;
            state_in       = S_FHW;
         end
         // open the start tile
         S_FHW: begin
            if (heur_rsp.done) begin
               tile_we         = 1'b1;
               tile_waddr      = s_idx;
               tile_wdata.mark = MARK_OPEN;
               tile_wdata.h    = heur_rsp.h;
               order_in        = ORD_W'(1);
               end_open_in     = (s_idx == e_idx);
               state_in        = S_CHK;
            end
         end
         S_CHK: begin
            if (end_open_ff) begin
               state_in = S_POCC;
            end else begin
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         // one tile read per cycle, the data registered and seen the cycle after its address
         S_SCAN: begin
            tile_raddr = cnt_ff[IDX_W-1:0];
            if ((cnt_ff != '0) && take) begin
               found_in    = 1'b1;
               best_in     = tile_rd_ff;
               best_idx_in = k_c[IDX_W-1:0];
               best_f_in   = f_c;
            end
            if (cnt_ff == CNT_W'(TILES)) begin
               state_in = S_CLOSE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_CLOSE: begin
            if (!found_ff) begin
               stored_len_in = '0;
               res_status_in = STAT_NOPATH;
               state_in      = S_DONE;
            end else begin
               tile_we         = 1'b1;
               tile_waddr      = best_idx_ff;
               tile_wdata      = best_ff;
               tile_wdata.mark = MARK_CLOSED;
               d_in            = '0;
               state_in        = S_NBR;
            end
         end
         // issue reads of the neighbour
         S_NBR: begin
            if (n_in_map) begin
               nidx_in  = n_idx;
               state_in = S_NEV;
            end else begin
               state_in = (d_ff == DIR_W'(7)) ? S_CHK : S_NBR;
               d_in     = d_ff + DIR_W'(1);
            end
         end
         S_NEV: begin
            gnew_in  = gnew_c;
            state_in = (d_ff == DIR_W'(7)) ? S_CHK : S_NBR;
            d_in     = d_ff + DIR_W'(1);
            if (blocked || (tile_rd_ff.mark == MARK_CLOSED)) begin
               // skipped
            end else if (tile_rd_ff.mark == MARK_NONE) begin
               heur_req.start = 1'b1;
               state_in       = S_NH;
               d_in           = d_ff;
            end else if (gnew_c < tile_rd_ff.g) begin
               tile_we        = 1'b1;
               tile_wdata     = tile_rd_ff;
               tile_wdata.g   = gnew_c;
               tile_wdata.dir = d_ff;
            end
         end
         // insert a new open tile
         S_NH: begin
            if (heur_rsp.done) begin
               tile_we         = 1'b1;
               tile_wdata.mark = MARK_OPEN;
               tile_wdata.g    = gnew_ff;
               tile_wdata.dir  = d_ff;
               tile_wdata.ord  = order_ff;
               tile_wdata.h    = heur_rsp.h;
               order_in        = order_ff + ORD_W'(1);
               if (nidx_ff == e_idx) end_open_in = 1'b1;
               state_in        = (d_ff == DIR_W'(7)) ? S_CHK : S_NBR;
               d_in            = d_ff + DIR_W'(1);
            end
         end
         S_POCC: begin
            occ_raddr = e_idx;
            state_in  = S_PEO;
         end
         S_PEO: begin
            end_occ_in = occ_rd_ff;
            pidx_in    = e_idx;
            full_in    = '0;
            state_in   = S_P1;
         end
         // first trace: count the steps
         S_P1: begin
            tile_raddr = pidx_ff;
            if ((pidx_ff == s_idx) || full_ff[CNT_W-1]) begin
               len_in   = (end_occ_ff && (full_ff != '0)) ? full_ff - CNT_W'(1) : full_ff;
               cnt_in   = full_ff;
               pidx_in  = e_idx;
               fin_in   = s_idx;
               state_in = S_P2;
            end else begin
               state_in = S_P1E;
            end
         end
         S_P1E: begin
            pidx_in  = p_idx;
            full_in  = full_ff + CNT_W'(1);
            state_in = S_P1;
         end
         // second trace: store steps from the far end
         S_P2: begin
            tile_raddr = pidx_ff;
            if (cnt_ff == '0) begin
               state_in = S_MV0;
            end else begin
               if (k_c < len_ff) path_we = 1'b1;
               if (cnt_ff == len_ff) fin_in = pidx_ff;
               state_in = S_P2E;
            end
         end
         S_P2E: begin
            pidx_in  = p_idx;
            cnt_in   = k_c;
            state_in = S_P2;
         end
         // move the unit
         S_MV0: begin
            occ_we   = 1'b1;
            state_in = S_MV1;
         end
         S_MV1: begin
            occ_we        = 1'b1;
            occ_waddr     = fin_ff;
            occ_wdata     = 1'b1;
            stored_len_in = len_ff;
            res_status_in = STAT_FOUND;
            state_in      = S_DONE;
         end
         // hand the result word to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_len_in    = stored_len_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_RCLR;
         cnt_ff        <= '0;
         map_w_ff      <= GRID_V;
         map_h_ff      <= GRID_V;
         stored_len_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         end_open_ff   <= 1'b0;
         d_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         map_w_ff      <= map_w_in;
         map_h_ff      <= map_h_in;
         stored_len_ff <= stored_len_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
         end_open_ff   <= end_open_in;
         d_ff          <= d_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      occv_ff       <= occv_in;
      si_ff         <= si_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_f_ff     <= best_f_in;
      nidx_ff       <= nidx_in;
      gnew_ff       <= gnew_in;
      order_ff      <= order_in;
      end_occ_ff    <= end_occ_in;
      pidx_ff       <= pidx_in;
      full_ff       <= full_in;
      len_ff        <= len_in;
      fin_ff        <= fin_in;
   end

   // occupancy memory
   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
      occ_rd_ff <= occ_mem[occ_raddr];
   end

   // tile memory
   always_ff @(posedge clock) begin
      if (tile_we) tile_mem[tile_waddr] <= tile_wdata;
      tile_rd_ff <= tile_mem[tile_raddr];
   end

   // path memory
   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_waddr] <= pidx_ff;
      path_rd_ff <= path_mem[si_ff];
   end

   // channel outputs
   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.path_length = rsp_len_ff;
   assign rsp_ch.step_x      = rsp_x_ff;
   assign rsp_ch.step_y      = rsp_y_ff;

`ifndef SYNTHESIS
   a_close_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLOSE && found_ff) |-> (best_ff.mark == MARK_OPEN))
      else $error("expanded tile was not open");
   a_scan_no_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !end_open_ff)
      else $error("scan started with end tile already open");
   a_heur_wait: assert property (@(posedge clock) disable iff (reset)
      heur_rsp.done |-> (state_ff == S_FHW || state_ff == S_NH))
      else $error("heuristic answer arrived with nobody waiting");
   a_len_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P2) |-> (len_ff <= full_ff))
      else $error("stored length exceeds traced length");
`endif

endmodule

[dv/tb_top.sv]
// tb_top: self-checking bench for grid_astar_path_finder (write, find, read words)
// keeps its own A* predictor and occupancy map and checks every result word in order
// depends on gapf_pkg, gapf_req_if, gapf_rsp_if and the block itself
module tb_top;
   import gapf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int IDLE_LIMIT = 1500000;
   localparam int PATH_MAX = 1024;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [LEN_W-1:0]   path_length;
      logic [COORD_W-1:0] step_x;
      logic [COORD_W-1:0] step_y;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = REG_MAP_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   gapf_req_if req_ch ();
   gapf_rsp_if rsp_ch ();

   grid_astar_path_finder dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // predicted grid state and search records
   bit occ_map[TILES];
   int list_mark[TILES];
   int cost_g[TILES];
   int came_dir[TILES];
   int open_order[TILES];
   int heur_val[TILES];
   int route_tiles[PATH_MAX];
   int route_len = 0;
   int map_w = 32;
   int map_h = 32;
   int dx_tab[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
   int dy_tab[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

   result_word_type expected_words[$];
   int mismatches = 0;
   int words_sent = 0;
   int n_found = 0, n_blocked = 0, n_range = 0, n_steps_read = 0;
   bit hold_request = 1'b0;
   int hold_cycles = 0;
   bit no_idle = 1'b0;

   // rounded euclidean distance in tenths
   function automatic int tenth_dist(int x, int y, int ex, int ey);
      int ax, ay, v, n;
      ax = x > ex ? x - ex : ex - x;
      ay = y > ey ? y - ey : ey - y;
      v = 100 * (ax * ax + ay * ay);
      n = 0;
      while ((n + 1) * (n + 1) <= v) n++;
      if (4 * v >= (2 * n + 1) * (2 * n + 1)) n++;
      return n;
   endfunction

   // a* over the used corner; 1 when the goal got opened
   function automatic bit astar_reaches(int sx, int sy, int ex, int ey, int w, int h);
      int s, e, best, counter, bx, by, nx, ny, nt, g, f, bf;
      bit found;
      s = sy * GRID_DIM + sx;
      e = ey * GRID_DIM + ex;
      counter = 1;
      foreach (list_mark[i]) list_mark[i] = 0;
      list_mark[s] = 1;
      cost_g[s] = 0;
      open_order[s] = 0;
      came_dir[s] = 0;
      heur_val[s] = tenth_dist(sx, sy, ex, ey);
      forever begin
         if (list_mark[e] == 1) return 1'b1;
         found = 1'b0;
         best = 0;
         for (int i = 0; i < TILES; i++) begin
            if (list_mark[i] != 1) continue;
            if (!found) begin
               best = i;
               found = 1'b1;
               continue;
            end
            f = cost_g[i] + heur_val[i];
            bf = cost_g[best] + heur_val[best];
            if (f < bf || (f == bf && open_order[i] < open_order[best])) best = i;
         end
         if (!found) return 1'b0;
         list_mark[best] = 2;
         bx = best % GRID_DIM;
         by = best / GRID_DIM;
         for (int d = 0; d < 8; d++) begin
            nx = bx + dx_tab[d];
            ny = by + dy_tab[d];
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
            nt = ny * GRID_DIM + nx;
            if (occ_map[nt] && nt != e) continue;
            if (list_mark[nt] == 2) continue;
            g = cost_g[best] + ((d & 1) ? COST_DIAG : COST_STRAIGHT);
            if (list_mark[nt] == 0) begin
               list_mark[nt] = 1;
               cost_g[nt] = g;
               came_dir[nt] = d;
               open_order[nt] = counter++;
               heur_val[nt] = tenth_dist(nx, ny, ex, ey);
            end else if (g < cost_g[nt]) begin
               cost_g[nt] = g;
               came_dir[nt] = d;
            end
         end
      end
   endfunction

   function automatic int back_tile(int t);
      int x, y;
      x = t % GRID_DIM - dx_tab[came_dir[t]];
      y = t / GRID_DIM - dy_tab[came_dir[t]];
      if (x < 0 || y < 0 || x >= GRID_DIM || y >= GRID_DIM) return t;
      return y * GRID_DIM + x;
   endfunction

   // walk parents back, store the route and move the unit
   function automatic void store_route(int sx, int sy, int ex, int ey);
      int s, e, t, full, len, fin;
      s = sy * GRID_DIM + sx;
      e = ey * GRID_DIM + ex;
      t = e;
      full = 0;
      fin = s;
      while (t != s && full < TILES) begin
         full++;
         t = back_tile(t);
      end
      len = full;
      if (occ_map[e] && len > 0) len--;
      t = e;
      for (int k = full - 1; k >= 0; k--) begin
         if (k < len && k < PATH_MAX) route_tiles[k] = t;
         if (k + 1 == len) fin = t;
         t = back_tile(t);
      end
      route_len = len < PATH_MAX ? len : PATH_MAX;
      occ_map[s] = 1'b0;
      occ_map[fin] = 1'b1;
   endfunction

   function automatic result_word_type predict_word(logic [CMD_W-1:0] cmd, int sx, int sy,
                                                    int ex, int ey, bit occ, int si);
      result_word_type r;
      int w, h;
      bit start_ok;
      w = map_w > GRID_DIM ? GRID_DIM : map_w;
      h = map_h > GRID_DIM ? GRID_DIM : map_h;
      start_ok = sx < w && sy < h;
      r = '0;
      r.status = STAT_RANGE;
      case (cmd)
         CMD_WRITE: begin
            if (start_ok) begin
               occ_map[sy * GRID_DIM + sx] = occ;
               r.status = STAT_DONE;
            end
         end
         CMD_FIND: begin
            if (start_ok && ex < w && ey < h) begin
               if (astar_reaches(sx, sy, ex, ey, w, h)) begin
                  store_route(sx, sy, ex, ey);
                  r.status = STAT_FOUND;
                  n_found++;
               end else begin
                  route_len = 0;
                  r.status = STAT_NOPATH;
                  n_blocked++;
               end
            end
         end
         CMD_READ: begin
            if (si < route_len) begin
               r.step_x = COORD_W'(route_tiles[si] % GRID_DIM);
               r.step_y = COORD_W'(route_tiles[si] / GRID_DIM);
               r.status = STAT_DONE;
               n_steps_read++;
            end
         end
         default: ;
      endcase
      if (r.status == STAT_RANGE) n_range++;
      r.path_length = LEN_W'(route_len);
      return r;
   endfunction

   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // send one command word; entered and left at a falling edge
   task automatic send_word(logic [CMD_W-1:0] cmd, int sx, int sy, int ex, int ey,
                            bit occ, int si);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.command        <= cmd;
      req_ch.start_x        <= COORD_W'(sx);
      req_ch.start_y        <= COORD_W'(sy);
      req_ch.end_x          <= COORD_W'(ex);
      req_ch.end_y          <= COORD_W'(ey);
      req_ch.occupied_value <= occ;
      req_ch.step_index     <= STEP_W'(si);
      req_ch.valid          <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      expected_words.insert(expected_words.size(),
                            predict_word(cmd, sx, sy, ex, ey, occ, si));
      words_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding word
   task automatic drain_all();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, int val);
      drain_all();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_MAP_WIDTH) map_w = val;
      else map_h = val;
   endtask

   // receiver side: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) < 3)
               stall_left = $urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                      : $urandom_range(15, 80);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      result_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            mismatches++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_ch.status !== exp_w.status) begin
               $error("status expected %0d actual %0d", exp_w.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.path_length !== exp_w.path_length) begin
               $error("path_length expected %0d actual %0d", exp_w.path_length,
                      rsp_ch.path_length);
               mismatches++;
            end
            if (rsp_ch.step_x !== exp_w.step_x) begin
               $error("step_x expected %0d actual %0d", exp_w.step_x, rsp_ch.step_x);
               mismatches++;
            end
            if (rsp_ch.step_y !== exp_w.step_y) begin
               $error("step_y expected %0d actual %0d", exp_w.step_y, rsp_ch.step_y);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet = 0;
      else begin
         quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // command corner cases on the full default map
   task automatic test_basic_commands();
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, 0);
      send_word(CMD_READ, 31, 31, 31, 31, 1'b1, 1023);
      send_word(CMD_UNKNOWN, 31, 31, 31, 31, 1'b1, 1023);
      send_word(CMD_WRITE, 31, 31, 0, 0, 1'b1, 0);
      send_word(CMD_WRITE, 31, 31, 0, 0, 1'b0, 0);
      send_word(CMD_FIND, 5, 5, 5, 5, 1'b0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, 0);
   endtask

   // long diagonal route across the whole grid
   task automatic test_open_field_route();
      send_word(CMD_FIND, 0, 0, 31, 31, 1'b0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, route_len > 0 ? route_len - 1 : 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, route_len);
   endtask

   // occupied goal: route stops one step short
   task automatic test_blocked_goal();
      send_word(CMD_WRITE, 10, 2, 0, 0, 1'b1, 0);
      send_word(CMD_FIND, 6, 2, 10, 2, 1'b0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, 2);
   endtask

   // oversized, zero and tiny map sizes, and an unreachable goal
   task automatic test_register_extremes();
      write_reg(REG_MAP_WIDTH, 40);
      write_reg(REG_MAP_HEIGHT, 0);
      send_word(CMD_WRITE, 0, 0, 0, 0, 1'b1, 0);
      send_word(CMD_FIND, 0, 0, 1, 1, 1'b0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, 0);
      write_reg(REG_MAP_WIDTH, 3);
      write_reg(REG_MAP_HEIGHT, 1);
      send_word(CMD_WRITE, 0, 1, 0, 0, 1'b1, 0);
      send_word(CMD_WRITE, 1, 0, 0, 0, 1'b1, 0);
      send_word(CMD_FIND, 0, 0, 2, 0, 1'b0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 1'b0, 0);
      write_reg(REG_MAP_WIDTH, 1);
      write_reg(REG_MAP_HEIGHT, 1);
      send_word(CMD_FIND, 0, 0, 0, 0, 1'b0, 0);
   endtask

   // receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_cycles = 400;
      hold_request = 1'b1;
      for (int i = 0; i < 8; i++)
         send_word(CMD_WRITE, 0, 0, $urandom_range(0, 31), 0, i[0], $urandom_range(0, 1023));
      drain_all();
      no_idle = 1'b0;
   endtask

   // random maps of small sizes: obstacles, searches and step reads
   task automatic test_random_maps();
      int shape_w[7] = '{4, 6, 5, 1, 7, 3, 2};
      int shape_h[7] = '{4, 6, 3, 7, 1, 5, 2};
      int r, w, h, sx, sy, ex, ey;
      for (int p = 0; p < 7; p++) begin
         write_reg(REG_MAP_WIDTH, shape_w[p]);
         write_reg(REG_MAP_HEIGHT, shape_h[p]);
         w = shape_w[p];
         h = shape_h[p];
         no_idle = (p == 2);
         for (int n = 0; n < 16; n++) begin
            r = $urandom_range(0, 99);
            sx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, w - 1);
            sy = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, h - 1);
            ex = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, w - 1);
            ey = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, h - 1);
            if (r < 45)
               send_word(CMD_WRITE, sx, sy, ex, ey, $urandom_range(0, 99) < 35,
                         $urandom_range(0, 1023));
            else if (r < 70)
               send_word(CMD_FIND, sx, sy, ex, ey, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 1023));
            else if (r < 95)
               send_word(CMD_READ, sx, sy, ex, ey, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 9) == 0 || route_len == 0)
                            ? $urandom_range(0, 1023) : $urandom_range(0, route_len - 1));
            else
               send_word(CMD_UNKNOWN, sx, sy, ex, ey, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 1023));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_WRITE;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.end_x = '0;
      req_ch.end_y = '0;
      req_ch.occupied_value = 1'b0;
      req_ch.step_index = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_basic_commands();
      test_open_field_route();
      test_blocked_goal();
      test_register_extremes();
      test_backpressure();
      test_random_maps();
      drain_all();
      repeat (50) @(negedge clock);
      $display("sent %0d command words: %0d routes found, %0d unreachable, %0d out of range",
               words_sent, n_found, n_blocked, n_range);
      $display("%0d route steps read back over %0d map shapes", n_steps_read, 11);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
